// ===== rtl/ale_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the array list engine.
// Used by ale_ctrl, ale_datapath and array_list_engine_core; depends on nothing.
package ale_pkg;

    localparam int ALE_CAPACITY    = 1024;
    localparam int ALE_OP_WIDTH    = 3;
    localparam int ALE_WORD_WIDTH  = 32;
    localparam int ALE_INDEX_WIDTH = 10;
    localparam int ALE_STAT_WIDTH  = 2;
    localparam int ALE_COUNT_WIDTH = 11;
    localparam int ALE_TDATA_WIDTH = 48;

    typedef enum logic [ALE_OP_WIDTH-1:0] {
        OP_APPEND  = 3'd0,
        OP_FIND    = 3'd1,
        OP_WRITE   = 3'd2,
        OP_READ    = 3'd3,
        OP_REVERSE = 3'd4,
        OP_REMOVE  = 3'd5
    } op_t;

    typedef enum logic [ALE_STAT_WIDTH-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_FIND_RD,
        S_FIND_CMP,
        S_READ_WAIT,
        S_REV_RDI,
        S_REV_RDJ,
        S_REV_WRI,
        S_REV_WRJ,
        S_RM_RD,
        S_RM_CMP,
        S_DONE
    } ctl_state_t;

    typedef enum logic [1:0] {
        RA_I,
        RA_J,
        RA_IDX
    } rd_addr_sel_t;

    typedef enum logic [1:0] {
        WA_COUNT,
        WA_IDX,
        WA_I,
        WA_J
    } wr_addr_sel_t;

    typedef enum logic [1:0] {
        WD_VALUE,
        WD_RDATA,
        WD_TMP
    } wr_data_sel_t;

    typedef struct packed {
        logic         load;
        logic         rd_en;
        rd_addr_sel_t rd_sel;
        logic         wr_en;
        wr_addr_sel_t wa_sel;
        wr_data_sel_t wd_sel;
        logic         tmp_ld;
        logic         i_inc;
        logic         j_top;
        logic         j_inc;
        logic         j_dec;
        logic         n_inc;
        logic         n_from_j;
        logic         st_miss;
        logic         st_full;
        logic         dat_i;
        logic         dat_rd;
        logic         out_ld;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic i_lt_n;
        logic i_lt_j;
        logic match;
        logic idx_ok;
        logic full;
        logic many;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/ale_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the array list engine: walks each operation through its states.
// Depends on ale_pkg; drives the datapath through dp_cmd_t and reads dp_status_t.
module ale_ctrl
    import ale_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (stat.op)
                    OP_FIND:    state_next = S_FIND_RD;
                    OP_READ:    state_next = stat.idx_ok ? S_READ_WAIT : S_DONE;
                    OP_REVERSE: state_next = stat.many ? S_REV_RDI : S_DONE;
                    OP_REMOVE:  state_next = S_RM_RD;
                    default:    state_next = S_DONE;
                endcase
            end
            S_FIND_RD:   state_next = stat.i_lt_n ? S_FIND_CMP : S_DONE;
            S_FIND_CMP:  state_next = stat.match ? S_DONE : S_FIND_RD;
            S_READ_WAIT: state_next = S_DONE;
            S_REV_RDI:   state_next = stat.i_lt_j ? S_REV_RDJ : S_DONE;
            S_REV_RDJ:   state_next = S_REV_WRI;
            S_REV_WRI:   state_next = S_REV_WRJ;
            S_REV_WRJ:   state_next = S_REV_RDI;
            S_RM_RD:     state_next = stat.i_lt_n ? S_RM_CMP : S_DONE;
            S_RM_CMP:    state_next = S_RM_RD;
            S_DONE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // No word is taken while reset is held.
                s_tready = aresetn;
                cmd.load = s_tvalid && aresetn;
            end
            S_EXEC: begin
                unique case (stat.op)
                    OP_APPEND: begin
                        if (stat.full) begin
                            cmd.st_full = 1'b1;
                        end else begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_COUNT;
                            cmd.wd_sel = WD_VALUE;
                            cmd.n_inc  = 1'b1;
                        end
                    end
                    OP_WRITE: begin
                        if (stat.idx_ok) begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_IDX;
                            cmd.wd_sel = WD_VALUE;
                        end else begin
                            cmd.st_miss = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (stat.idx_ok) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_IDX;
                        end else begin
                            cmd.st_miss = 1'b1;
                        end
                    end
                    OP_REVERSE: cmd.j_top = 1'b1;
                    default: ;
                endcase
            end
            S_FIND_RD: begin
                if (stat.i_lt_n) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_I;
                end else begin
                    cmd.st_miss = 1'b1;
                end
            end
            S_FIND_CMP: begin
                if (stat.match) begin
                    cmd.dat_i = 1'b1;
                end else begin
                    cmd.i_inc = 1'b1;
                end
            end
            S_READ_WAIT: cmd.dat_rd = 1'b1;
            S_REV_RDI: begin
                if (stat.i_lt_j) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_I;
                end
            end
            S_REV_RDJ: begin
                // The read data register still holds the lower word here.
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_J;
                cmd.tmp_ld = 1'b1;
            end
            S_REV_WRI: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_I;
                cmd.wd_sel = WD_RDATA;
            end
            S_REV_WRJ: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_J;
                cmd.wd_sel = WD_TMP;
                cmd.i_inc  = 1'b1;
                cmd.j_dec  = 1'b1;
            end
            S_RM_RD: begin
                if (stat.i_lt_n) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_I;
                end else begin
                    cmd.n_from_j = 1'b1;
                end
            end
            S_RM_CMP: begin
                // Kept words are compacted down to the write pointer.
                if (!stat.match) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = WA_J;
                    cmd.wd_sel = WD_RDATA;
                    cmd.j_inc  = 1'b1;
                end
                cmd.i_inc = 1'b1;
            end
            S_DONE: cmd.out_ld = stat.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/ale_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the array list engine: word memory, count, pointers, result register.
// Depends on ale_pkg; controlled only through dp_cmd_t from ale_ctrl.
module ale_datapath
    import ale_pkg::*;
#(
    parameter int CAPACITY = ALE_CAPACITY
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ALE_TDATA_WIDTH-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ALE_TDATA_WIDTH-1:0] m_tdata,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 stat
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > ALE_INDEX_WIDTH) ? CW : ALE_INDEX_WIDTH;
    localparam int OW = (CW > ALE_COUNT_WIDTH) ? CW : ALE_COUNT_WIDTH;

    logic [ALE_WORD_WIDTH-1:0] mem [CAPACITY];

    logic [ALE_OP_WIDTH-1:0]    op_reg;
    logic [ALE_WORD_WIDTH-1:0]  value_reg;
    logic [ALE_INDEX_WIDTH-1:0] idx_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              i_reg;
    logic [CW-1:0]              j_reg;
    logic [ALE_WORD_WIDTH-1:0]  rdata_reg;
    logic [ALE_WORD_WIDTH-1:0]  tmp_reg;
    logic [ALE_WORD_WIDTH-1:0]  acc_data_reg;
    status_t                    acc_status_reg;

    logic                       m_valid_reg;
    logic [ALE_WORD_WIDTH-1:0]  m_data_reg;
    status_t                    m_status_reg;
    logic [ALE_COUNT_WIDTH-1:0] m_count_reg;

    logic [XW-1:0]             idx_ext;
    logic [OW-1:0]             count_ext;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             wr_addr;
    logic [ALE_WORD_WIDTH-1:0] wr_data;

    assign idx_ext   = XW'(idx_reg);
    assign count_ext = OW'(count_reg);

    always_comb begin
        unique case (cmd.rd_sel)
            RA_I:    rd_addr = i_reg[AW-1:0];
            RA_J:    rd_addr = j_reg[AW-1:0];
            RA_IDX:  rd_addr = idx_ext[AW-1:0];
            default: rd_addr = i_reg[AW-1:0];
        endcase
    end

    always_comb begin
        unique case (cmd.wa_sel)
            WA_COUNT: wr_addr = count_reg[AW-1:0];
            WA_IDX:   wr_addr = idx_ext[AW-1:0];
            WA_I:     wr_addr = i_reg[AW-1:0];
            WA_J:     wr_addr = j_reg[AW-1:0];
            default:  wr_addr = i_reg[AW-1:0];
        endcase
    end

    always_comb begin
        unique case (cmd.wd_sel)
            WD_VALUE: wr_data = value_reg;
            WD_RDATA: wr_data = rdata_reg;
            WD_TMP:   wr_data = tmp_reg;
            default:  wr_data = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= s_tdata[2:0];
            value_reg      <= s_tdata[34:3];
            idx_reg        <= s_tdata[44:35];
            i_reg          <= '0;
            j_reg          <= '0;
            acc_data_reg   <= '0;
            acc_status_reg <= STAT_OK;
        end else begin
            if (cmd.i_inc) begin
                i_reg <= i_reg + CW'(1);
            end
            if (cmd.j_top) begin
                j_reg <= count_reg - CW'(1);
            end else if (cmd.j_inc) begin
                j_reg <= j_reg + CW'(1);
            end else if (cmd.j_dec) begin
                j_reg <= j_reg - CW'(1);
            end
            if (cmd.st_miss) begin
                acc_status_reg <= STAT_MISS;
            end else if (cmd.st_full) begin
                acc_status_reg <= STAT_FULL;
            end
            if (cmd.dat_i) begin
                acc_data_reg <= ALE_WORD_WIDTH'(i_reg);
            end else if (cmd.dat_rd) begin
                acc_data_reg <= rdata_reg;
            end
        end
        if (cmd.tmp_ld) begin
            tmp_reg <= rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.n_inc) begin
            count_reg <= count_reg + CW'(1);
        end else if (cmd.n_from_j) begin
            count_reg <= j_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            m_data_reg   <= acc_data_reg;
            m_status_reg <= acc_status_reg;
            m_count_reg  <= count_ext[ALE_COUNT_WIDTH-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_count_reg, m_status_reg, m_data_reg};

    assign stat.op       = op_t'(op_reg);
    assign stat.i_lt_n   = (i_reg < count_reg);
    assign stat.i_lt_j   = (i_reg < j_reg);
    assign stat.match    = (rdata_reg == value_reg);
    assign stat.idx_ok   = (idx_ext < XW'(count_reg));
    assign stat.full     = (count_reg == CW'(CAPACITY));
    assign stat.many     = (count_reg > CW'(1));
    assign stat.out_free = !m_valid_reg || m_tready;

endmodule

// ===== rtl/array_list_engine_core.sv =====
`timescale 1ns / 1ps
// Array list engine: one word in, one result word out, one operation at a time.
// Append, write and bad-index read finish in the execute state; read then waits for
// the read word, while find, remove and reverse walk the stored words, paced by the
// word memory that serves one read or one write per cycle in the sequencer.
// The result appears in the same cycle as the next word can be taken, and a new word is
// taken once the previous result sits in the output register.
// Reset (aresetn low, synchronous) empties the list; memory contents are kept.
module array_list_engine_core
    import ale_pkg::*;
#(
    parameter int CAPACITY = ALE_CAPACITY
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // op [2:0], value [34:3], index [44:35], zero fill [47:45]
    input  logic [ALE_TDATA_WIDTH-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // data [31:0], status [33:32], count [44:34], zero fill [47:45]
    output logic [ALE_TDATA_WIDTH-1:0] m_tdata
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    ale_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ale_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
